>>> rtl/srpg_pkg.sv
// Package: shared types, codes and the period-update microprogram of the ramp generator.
`timescale 1ns / 1ps

package srpg_pkg;

  localparam int PERIOD_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int UPC_W     = 4;
  localparam int UCODE_LEN = 11;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_SETPOS = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PERIOD  = 3'd0,
    CFG_CRUISE_PERIOD = 3'd1,
    CFG_ACCEL_FACTOR  = 3'd2,
    CFG_RAMP_DISTANCE = 3'd3,
    CFG_TRAVEL_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RAMP_ACCEL  = 2'd0,
    RAMP_CRUISE = 2'd1,
    RAMP_DECEL  = 2'd2
  } ramp_mode_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_P_P   = 3'd0,
    MUL_K_SQL = 3'd1,
    MUL_K_SQH = 3'd2,
    MUL_P_TL  = 3'd3,
    MUL_P_TH  = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_ADD_HI = 2'd2
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     prod_we;
    acc_op_t  acc_op;
    logic     sq_we;
    logic     t_we;
  } pu_ctrl_t;

  typedef struct packed {
    logic     exec;          // evaluate the held item and post its result
    logic     skip_if_idle;  // finish here when no period update is due
    logic     last;          // final word of the program
    logic     per_we;        // load the updated step period
    pu_ctrl_t pu;
  } uword_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '0;
    unique case (addr)
      4'd0: begin
        w.exec         = 1'b1;
        w.skip_if_idle = 1'b1;
      end
      4'd1: begin
        w.pu.mul_sel = MUL_P_P;
        w.pu.prod_we = 1'b1;
      end
      4'd2: w.pu.sq_we = 1'b1;
      4'd3: begin
        w.pu.mul_sel = MUL_K_SQL;
        w.pu.prod_we = 1'b1;
      end
      4'd4: begin
        w.pu.acc_op  = ACC_LOAD;
        w.pu.mul_sel = MUL_K_SQH;
        w.pu.prod_we = 1'b1;
      end
      4'd5: w.pu.acc_op = ACC_ADD_HI;
      4'd6: w.pu.t_we = 1'b1;
      4'd7: begin
        w.pu.mul_sel = MUL_P_TL;
        w.pu.prod_we = 1'b1;
      end
      4'd8: begin
        w.pu.acc_op  = ACC_LOAD;
        w.pu.mul_sel = MUL_P_TH;
        w.pu.prod_we = 1'b1;
      end
      4'd9: w.pu.acc_op = ACC_ADD_HI;
      4'd10: begin
        w.per_we = 1'b1;
        w.last   = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/srpg_in_if.sv
// Interface: input channel of the ramp generator (operation, target and endstop levels).
`timescale 1ns / 1ps

interface srpg_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] target_position;
  logic              endstop_low_level;
  logic              endstop_high_level;

  modport source (
    output valid, operation, target_position, endstop_low_level, endstop_high_level,
    input  ready
  );

  modport sink (
    input  valid, operation, target_position, endstop_low_level, endstop_high_level,
    output ready
  );
endinterface

>>> rtl/srpg_out_if.sv
// Interface: result channel of the ramp generator (step, status flags and position).
`timescale 1ns / 1ps

interface srpg_out_if;
  logic               valid;
  logic               ready;
  logic               step_pulse;
  logic               direction;
  logic               moving;
  logic               move_done;
  logic               out_of_range;
  logic               endstop_abort;
  logic signed [31:0] current_position;

  modport source (
    output valid, step_pulse, direction, moving, move_done, out_of_range, endstop_abort,
           current_position,
    input  ready
  );

  modport sink (
    input  valid, step_pulse, direction, moving, move_done, out_of_range, endstop_abort,
           current_position,
    output ready
  );
endinterface

>>> rtl/srpg_period_unit.sv
// Period update datapath: shared 32x32 multiplier, accumulator and the final saturating step.
`timescale 1ns / 1ps

module srpg_period_unit #(
  parameter int PERIOD_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  srpg_pkg::pu_ctrl_t                 ctrl,
  input  logic [srpg_pkg::PERIOD_W-1:0]      period,
  input  logic [31:0]                        accel,
  input  logic                               decel,
  output logic [srpg_pkg::PERIOD_W-1:0]      period_next
);

  // k*p^2 carries Q16.16 times two period fractions
  localparam int SHIFT = 16 + 2 * PERIOD_FRAC_BITS;

  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  prod_r;
  logic [63:0]  sq_r;
  logic [63:0]  t_r;
  logic [127:0] acc_r;
  logic [127:0] acc_nxt;
  logic [127:0] acc_shift;
  logic [63:0]  delta;
  logic [32:0]  sum;

  always_comb begin
    unique case (ctrl.mul_sel)
      srpg_pkg::MUL_P_P: begin
        mul_a = period;
        mul_b = period;
      end
      srpg_pkg::MUL_K_SQL: begin
        mul_a = accel;
        mul_b = sq_r[31:0];
      end
      srpg_pkg::MUL_K_SQH: begin
        mul_a = accel;
        mul_b = sq_r[63:32];
      end
      srpg_pkg::MUL_P_TL: begin
        mul_a = period;
        mul_b = t_r[31:0];
      end
      srpg_pkg::MUL_P_TH: begin
        mul_a = period;
        mul_b = t_r[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.acc_op)
      srpg_pkg::ACC_HOLD:   acc_nxt = acc_r;
      srpg_pkg::ACC_LOAD:   acc_nxt = {64'b0, prod_r};
      srpg_pkg::ACC_ADD_HI: acc_nxt = acc_r + {32'b0, prod_r, 32'b0};
      default:              acc_nxt = acc_r;
    endcase
  end

  assign acc_shift = acc_r >> SHIFT;

  always_ff @(posedge clk) begin
    if (ctrl.prod_we) begin
      prod_r <= {32'b0, mul_a} * {32'b0, mul_b};
    end
    if (ctrl.sq_we) begin
      sq_r <= prod_r;
    end
    if (ctrl.t_we) begin
      t_r <= acc_shift[63:0];
    end
    acc_r <= acc_nxt;
  end

  // delta = p*t >> 32; speed up subtracts it, slow down adds it
  assign delta = acc_r[95:32];
  assign sum   = {1'b0, period} + {1'b0, delta[31:0]};

  always_comb begin
    if (decel) begin
      if ((|delta[63:32]) || sum[32]) begin
        period_next = '1;
      end else begin
        period_next = sum[31:0];
      end
    end else begin
      if (delta >= {32'b0, period}) begin
        period_next = '0;
      end else begin
        period_next = period - delta[31:0];
      end
    end
  end

endmodule

>>> rtl/stepper_ramp_pulse_generator_core.sv
// Top level: trapezoidal stepper ramp pulse generator driven by a small microprogram.
`timescale 1ns / 1ps

// Usage
// The in_ch channel carries one transaction per operation: microsecond tick,
// start move to an absolute target, set position, or no-op. Every input
// transaction yields exactly one result transaction on out_ch with the step
// pulse, direction, moving, done/abort/range flags and the position after it.
// The cfg_ port writes the five ramp registers by index, one per cycle; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Flow: a transaction is taken into a holding register, evaluated at the
// first program step once the result slot is free, and its result is
// registered on out_ch. No new transaction is accepted until the program
// for the held one has finished. A step taken while accelerating or
// decelerating then runs the 10-step period program on the single 32x32
// multiplier. If out_ch stalls, one more transaction is still accepted and
// held; it is evaluated once the waiting result is taken, and in_ch.ready
// stays low until then.
// Reset (synchronous, rst_n low) loads the register defaults, clears position
// and motion state and empties both channels; no clearing pass is needed.

module stepper_ramp_pulse_generator_core #(
  parameter int PERIOD_FRAC_BITS = 16,
  parameter int POSITION_BITS    = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  srpg_in_if.sink                            in_ch,
  srpg_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam int PB    = POSITION_BITS;
  localparam int CW    = (PB > 31) ? PB : 31;
  localparam int EXT_W = (PB > 32) ? PB : 32;

  // configuration
  logic [31:0] fp_r;
  logic [31:0] cp_r;
  logic [31:0] k_r;
  logic [30:0] rdf_r;
  logic [30:0] tl_r;

  // held transaction
  logic [1:0]         item_op_r;
  logic signed [31:0] item_tgt_r;
  logic               item_lo_r;
  logic               item_hi_r;

  // sequencer
  logic                       run_r;
  logic [srpg_pkg::UPC_W-1:0] upc_r;
  srpg_pkg::uword_t           uw;

  // motion state
  logic [PB-1:0]           pos_r, pos_nxt;
  logic [PB-1:0]           tgt_r, tgt_nxt;
  logic                    dir_r, dir_nxt;
  logic [31:0]             per_r, per_nxt;
  logic [31:0]             elap_r, elap_nxt;
  srpg_pkg::ramp_mode_t    mode_r, mode_nxt;
  logic [PB-1:0]           decel_r, decel_nxt;
  logic [1:0]              estop_r, estop_nxt;
  logic                    active_r, active_nxt;

  // result register
  logic               out_valid_r;
  logic               res_step_r, res_dir_r, res_moving_r;
  logic               res_done_r, res_oor_r, res_abort_r;
  logic signed [31:0] res_pos_r;

  logic res_step, res_done, res_oor, res_abort;
  logic upd;

  logic in_fire;
  logic out_free;
  logic exec_fire;

  logic [PB-1:0]    tin_pos;
  logic             start_oor;
  logic [PB-1:0]    start_tgt;
  logic signed [PB:0] rel;
  logic [PB:0]      rel_mag;
  logic [PB-1:0]    half;
  logic [PB-1:0]    decel_cand;
  logic signed [PB:0] remain;
  logic [PB:0]      dist_mag;
  logic             dist_le;
  logic [31:0]      elap_inc;
  logic             due;
  logic [PB-1:0]    pos_step;
  logic             changed;
  logic [EXT_W-1:0] pos_ext;
  logic [31:0]      pu_period_next;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign uw        = srpg_pkg::ucode(upc_r);
  assign exec_fire = run_r && uw.exec && out_free;
  assign in_ch.ready = !run_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r  <= 32'd3276800000;
      cp_r  <= 32'd327680000;
      k_r   <= 32'd56295;
      rdf_r <= 31'd100;
      tl_r  <= 31'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srpg_pkg::CFG_FIRST_PERIOD:  fp_r  <= cfg_wdata;
        srpg_pkg::CFG_CRUISE_PERIOD: cp_r  <= cfg_wdata;
        srpg_pkg::CFG_ACCEL_FACTOR:  k_r   <= cfg_wdata;
        srpg_pkg::CFG_RAMP_DISTANCE: rdf_r <= cfg_wdata[30:0];
        srpg_pkg::CFG_TRAVEL_LIMIT:  tl_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op_r  <= in_ch.operation;
      item_tgt_r <= in_ch.target_position;
      item_lo_r  <= in_ch.endstop_low_level;
      item_hi_r  <= in_ch.endstop_high_level;
    end
  end

  // step counter: hold at the evaluate step while the result slot is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upc_r <= '0;
    end else if (!run_r) begin
      if (in_fire) begin
        run_r <= 1'b1;
        upc_r <= '0;
      end
    end else if (uw.exec && !out_free) begin
      upc_r <= upc_r;
    end else if (uw.last || (uw.skip_if_idle && !upd)) begin
      run_r <= 1'b0;
    end else begin
      upc_r <= upc_r + srpg_pkg::UPC_W'(1);
    end
  end

  // start move terms
  assign tin_pos   = PB'($signed(item_tgt_r));
  assign start_oor = item_tgt_r[31] || (item_tgt_r[30:0] > tl_r);
  assign start_tgt = start_oor ? pos_r : tin_pos;
  assign rel       = $signed({start_tgt[PB-1], start_tgt}) - $signed({pos_r[PB-1], pos_r});
  assign rel_mag   = rel[PB] ? (PB+1)'(-rel) : (PB+1)'(rel);
  assign half      = rel_mag[PB:1];
  assign decel_cand = (CW'(half) < CW'(rdf_r)) ? half : PB'(rdf_r);

  // tick terms
  assign changed  = (estop_r != {item_hi_r, item_lo_r});
  assign elap_inc = (elap_r != '1) ? elap_r + 32'd1 : elap_r;
  assign due      = {elap_inc, {PERIOD_FRAC_BITS{1'b0}}} >= (32 + PERIOD_FRAC_BITS)'(per_r);
  assign remain   = $signed({tgt_r[PB-1], tgt_r}) - $signed({pos_r[PB-1], pos_r});
  assign dist_mag = remain[PB] ? (PB+1)'(-remain) : (PB+1)'(remain);
  assign dist_le  = dist_mag <= {1'b0, decel_r};
  assign pos_step = dir_r ? pos_r - PB'(1) : pos_r + PB'(1);

  always_comb begin
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    dir_nxt    = dir_r;
    per_nxt    = per_r;
    elap_nxt   = elap_r;
    mode_nxt   = mode_r;
    decel_nxt  = decel_r;
    estop_nxt  = estop_r;
    active_nxt = active_r;
    res_step   = 1'b0;
    res_done   = 1'b0;
    res_oor    = 1'b0;
    res_abort  = 1'b0;
    upd        = 1'b0;
    if (exec_fire) begin
      case (item_op_r)
        srpg_pkg::OP_START: begin
          res_oor = start_oor;
          tgt_nxt = start_tgt;
          if (rel < 0) begin
            dir_nxt = 1'b1;
          end else if (rel > 0) begin
            dir_nxt = 1'b0;
          end
          decel_nxt  = decel_cand;
          per_nxt    = fp_r;
          elap_nxt   = '0;
          mode_nxt   = srpg_pkg::RAMP_ACCEL;
          active_nxt = (rel != 0);
          res_done   = (rel == 0);
        end
        srpg_pkg::OP_SETPOS: begin
          pos_nxt    = tin_pos;
          res_done   = active_r;
          active_nxt = 1'b0;
        end
        srpg_pkg::OP_TICK: begin
          if (active_r) begin
            estop_nxt = {item_hi_r, item_lo_r};
            if (changed) begin
              active_nxt = 1'b0;
              res_done   = 1'b1;
              res_abort  = 1'b1;
            end else if (!due) begin
              elap_nxt = elap_inc;
            end else begin
              elap_nxt = '0;
              if (dist_le) begin
                mode_nxt = srpg_pkg::RAMP_DECEL;
              end
              // the cruise clamp wins over a decelerate decision on the same step
              if (per_r < cp_r) begin
                per_nxt  = cp_r;
                mode_nxt = srpg_pkg::RAMP_CRUISE;
              end
              upd      = (mode_nxt == srpg_pkg::RAMP_ACCEL) ||
                         (mode_nxt == srpg_pkg::RAMP_DECEL);
              pos_nxt  = pos_step;
              res_step = 1'b1;
              if (pos_step == tgt_r) begin
                active_nxt = 1'b0;
                res_done   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (run_r && uw.per_we) begin
      per_nxt = pu_period_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tgt_r    <= '0;
      dir_r    <= 1'b0;
      per_r    <= '0;
      elap_r   <= '0;
      mode_r   <= srpg_pkg::RAMP_ACCEL;
      decel_r  <= '0;
      estop_r  <= 2'b11;
      active_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      tgt_r    <= tgt_nxt;
      dir_r    <= dir_nxt;
      per_r    <= per_nxt;
      elap_r   <= elap_nxt;
      mode_r   <= mode_nxt;
      decel_r  <= decel_nxt;
      estop_r  <= estop_nxt;
      active_r <= active_nxt;
    end
  end

  srpg_period_unit #(
    .PERIOD_FRAC_BITS (PERIOD_FRAC_BITS)
  ) u_period (
    .clk         (clk),
    .ctrl        (uw.pu),
    .period      (per_r),
    .accel       (k_r),
    .decel       (mode_r == srpg_pkg::RAMP_DECEL),
    .period_next (pu_period_next)
  );

  // result register
  assign pos_ext = EXT_W'($signed(pos_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_step_r   <= res_step;
      res_dir_r    <= dir_nxt;
      res_moving_r <= active_nxt;
      res_done_r   <= res_done;
      res_oor_r    <= res_oor;
      res_abort_r  <= res_abort;
      res_pos_r    <= pos_ext[31:0];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.step_pulse       = res_step_r;
  assign out_ch.direction        = res_dir_r;
  assign out_ch.moving           = res_moving_r;
  assign out_ch.move_done        = res_done_r;
  assign out_ch.out_of_range     = res_oor_r;
  assign out_ch.endstop_abort    = res_abort_r;
  assign out_ch.current_position = res_pos_r;

`ifndef SYNTHESIS
  a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> run_r && (upc_r == '0))
    else $error("accepted transaction did not start the program at its first step");

  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(run_r) && ($past(upc_r) == '0))
    else $error("result posted outside the evaluate step");

  a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (upc_r < srpg_pkg::UPC_W'(srpg_pkg::UCODE_LEN)))
    else $error("step counter ran past the program");

  a_accel_shortens: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && uw.per_we && (mode_r == srpg_pkg::RAMP_ACCEL) |=> per_r <= $past(per_r))
    else $error("period grew while accelerating");

  a_decel_lengthens: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && uw.per_we && (mode_r == srpg_pkg::RAMP_DECEL) |=> per_r >= $past(per_r))
    else $error("period shrank while decelerating");
`endif

endmodule
